[rtl/mcm_pkg.sv]
// ---------------------------------------------------------------------------
// mcm_pkg - shared types and constants for the column matrix multiplier
// Holds the controller state type, the command/status structs between the
// controller and the datapath, and the fixed field sizes.
// ---------------------------------------------------------------------------
package mcm_pkg;

    // Field sizes fixed by the interface
    localparam int DATA_W   = 32;
    localparam int COL_W    = 2;
    localparam int IN_ROWS  = 4;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_MUL  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_WRITE
    } mcm_state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load_col;   // write one left column from the input beat
        logic start_mul;  // capture right column, clear accumulators
        logic mul_en;     // multiply one element per lane, advance index
        logic acc_en;     // add the registered products into the sums
        logic out_load;   // round, saturate and fill the output register
    } mcm_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic mac_first;  // no product registered yet for this column
        logic mac_last;   // element index points at the last column
        logic out_stall;  // output register holds a beat not yet taken
    } mcm_status_t;

endpackage

[rtl/matrix4_column_multiply.sv]
// ---------------------------------------------------------------------------
// matrix4_column_multiply - signed Q16.16 matrix times column
// Stores a left matrix loaded column by column and multiplies right
// columns against it, one product column per multiply beat.
// ---------------------------------------------------------------------------
// A load beat (kind 0) writes one left column. A multiply beat (kind 1)
// returns one product column, N = min(DIM,4): one row lane per product
// row runs one 32x32 multiply a cycle over the N stored columns, then a
// drain step adds the last product and a write step rounds and saturates
// into the output register. The next beat is taken once that register is
// filled. Sums are exact, shifted right 16 (floor) and clamped to 32
// bits; sat_flag is set when any row is clamped. Beats with a column
// number at or above DIM are dropped. The left matrix resets to zero.
module matrix4_column_multiply #(
    parameter int DIM = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [1:0]         s_col_index,
    input  logic signed [31:0] s_val_row0,
    input  logic signed [31:0] s_val_row1,
    input  logic signed [31:0] s_val_row2,
    input  logic signed [31:0] s_val_row3,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_out_col,
    output logic signed [31:0] m_prod_row0,
    output logic signed [31:0] m_prod_row1,
    output logic signed [31:0] m_prod_row2,
    output logic signed [31:0] m_prod_row3,
    output logic               m_sat_flag
);
    import mcm_pkg::*;

    mcm_cmd_t    cmd;
    mcm_status_t status;

    mcm_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_col_index (s_col_index),
        .status      (status),
        .cmd         (cmd)
    );

    mcm_datapath #(
        .DIM (DIM)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_col_index (s_col_index),
        .s_val_row0  (s_val_row0),
        .s_val_row1  (s_val_row1),
        .s_val_row2  (s_val_row2),
        .s_val_row3  (s_val_row3),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_col   (m_out_col),
        .m_prod_row0 (m_prod_row0),
        .m_prod_row1 (m_prod_row1),
        .m_prod_row2 (m_prod_row2),
        .m_prod_row3 (m_prod_row3),
        .m_sat_flag  (m_sat_flag)
    );

endmodule

[rtl/mcm_ctrl.sv]
// ---------------------------------------------------------------------------
// mcm_ctrl - sequencer for the column matrix multiplier
// Decodes input beats, steps the lane MACs over the stored columns and
// hands the finished sums to the output register.
// ---------------------------------------------------------------------------
module mcm_ctrl #(
    parameter int DIM = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [1:0]           s_col_index,
    input  mcm_pkg::mcm_status_t status,
    output mcm_pkg::mcm_cmd_t    cmd
);
    import mcm_pkg::*;

    mcm_state_t state_reg, state_next;
    logic       accept;
    logic       col_ok;

    assign accept = s_valid && s_ready;
    assign col_ok = (32'(s_col_index) < DIM);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && col_ok && s_kind == KIND_MUL) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (status.mac_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (!status.out_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_col  = accept && col_ok && s_kind == KIND_LOAD;
                cmd.start_mul = accept && col_ok && s_kind == KIND_MUL;
            end
            ST_MAC: begin
                cmd.mul_en = 1'b1;
            end
            ST_DRAIN: begin
                cmd.acc_en = 1'b1;
            end
            ST_WRITE: begin
                cmd.out_load = !status.out_stall;
            end
            default: begin
                cmd = '0;
            end
        endcase
        // Products from the previous cycle join the sum while multiplying
        if (state_reg == ST_MAC && !cmd.acc_en) begin
            cmd.acc_en = !status.mac_first;
        end
    end

endmodule

[rtl/mcm_datapath.sv]
// ---------------------------------------------------------------------------
// mcm_datapath - left matrix store, row MAC lanes and output register
// One lane per product row; each lane multiplies one stored element by
// one right-column element per cycle and keeps an exact wide sum.
// ---------------------------------------------------------------------------
module mcm_datapath #(
    parameter int DIM = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [1:0]                  s_col_index,
    input  logic signed [31:0]          s_val_row0,
    input  logic signed [31:0]          s_val_row1,
    input  logic signed [31:0]          s_val_row2,
    input  logic signed [31:0]          s_val_row3,
    input  mcm_pkg::mcm_cmd_t           cmd,
    output mcm_pkg::mcm_status_t        status,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_out_col,
    output logic signed [31:0]          m_prod_row0,
    output logic signed [31:0]          m_prod_row1,
    output logic signed [31:0]          m_prod_row2,
    output logic signed [31:0]          m_prod_row3,
    output logic                        m_sat_flag
);
    import mcm_pkg::*;

    // Only rows and columns below min(DIM, IN_ROWS) reach a result
    localparam int NLANE = (DIM < IN_ROWS) ? DIM : IN_ROWS;
    localparam int IDX_W = $clog2(NLANE);
    localparam int ACC_W = PROD_W + 2;
    localparam int SHR_W = ACC_W - FRAC_W;

    logic signed [DATA_W-1:0] in_rows [IN_ROWS];
    logic signed [DATA_W-1:0] left_reg [NLANE][NLANE];
    logic signed [DATA_W-1:0] right_reg [NLANE];
    logic signed [PROD_W-1:0] prod_reg [NLANE];
    logic signed [ACC_W-1:0]  acc_reg [NLANE];
    logic [IDX_W-1:0]         idx_reg;
    logic                     first_reg;
    logic [COL_W-1:0]         col_reg;

    logic signed [DATA_W-1:0] sat_val [IN_ROWS];
    logic [IN_ROWS-1:0]       sat_hit;

    logic                     valid_reg;
    logic [COL_W-1:0]         out_col_reg;
    logic signed [DATA_W-1:0] out_row_reg [IN_ROWS];
    logic                     sat_flag_reg;

    assign in_rows[0] = s_val_row0;
    assign in_rows[1] = s_val_row1;
    assign in_rows[2] = s_val_row2;
    assign in_rows[3] = s_val_row3;

    // Element index over the stored columns
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            first_reg <= 1'b1;
        end else if (cmd.start_mul) begin
            idx_reg   <= '0;
            first_reg <= 1'b1;
        end else if (cmd.mul_en) begin
            idx_reg   <= idx_reg + 1'b1;
            first_reg <= 1'b0;
        end
    end

    assign status.mac_last  = (idx_reg == IDX_W'(NLANE - 1));
    assign status.mac_first = first_reg;
    assign status.out_stall = valid_reg && !m_ready;

    // Right column and its column number
    always_ff @(posedge aclk) begin
        if (cmd.start_mul) begin
            col_reg <= s_col_index;
            for (int e = 0; e < NLANE; e++) begin
                right_reg[e] <= in_rows[e];
            end
        end
    end

    // Per-lane store, multiplier and accumulator
    for (genvar r = 0; r < NLANE; r++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                for (int c = 0; c < NLANE; c++) begin
                    left_reg[r][c] <= '0;
                end
            end else if (cmd.load_col) begin
                left_reg[r][s_col_index[IDX_W-1:0]] <= in_rows[r];
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.mul_en) begin
                prod_reg[r] <= left_reg[r][idx_reg] * right_reg[idx_reg];
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.start_mul) begin
                acc_reg[r] <= '0;
            end else if (cmd.acc_en) begin
                acc_reg[r] <= acc_reg[r] + ACC_W'(prod_reg[r]);
            end
        end

        // Floor shift then clamp to 32 bits
        logic signed [SHR_W-1:0] shr;
        assign shr = SHR_W'(acc_reg[r] >>> FRAC_W);
        always_comb begin
            priority if (shr > SHR_W'(32'sh7FFF_FFFF)) begin
                sat_val[r] = 32'sh7FFF_FFFF;
                sat_hit[r] = 1'b1;
            end else if (shr < SHR_W'(32'sh8000_0000)) begin
                sat_val[r] = 32'sh8000_0000;
                sat_hit[r] = 1'b1;
            end else begin
                sat_val[r] = shr[DATA_W-1:0];
                sat_hit[r] = 1'b0;
            end
        end
    end

    // Product rows with no lane read as zero
    for (genvar r = NLANE; r < IN_ROWS; r++) begin : g_zero
        assign sat_val[r] = '0;
        assign sat_hit[r] = 1'b0;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_col_reg  <= col_reg;
            sat_flag_reg <= |sat_hit;
            for (int r = 0; r < IN_ROWS; r++) begin
                out_row_reg[r] <= sat_val[r];
            end
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_col   = out_col_reg;
    assign m_prod_row0 = out_row_reg[0];
    assign m_prod_row1 = out_row_reg[1];
    assign m_prod_row2 = out_row_reg[2];
    assign m_prod_row3 = out_row_reg[3];
    assign m_sat_flag  = sat_flag_reg;

endmodule

[sim/tb_matrix4_column_multiply.sv]
// ---------------------------------------------------------------------------
// tb_matrix4_column_multiply - self-checking bench for the column multiplier
// Loads left columns and streams right columns through the valid/ready
// channels. A scoreboard class keeps its own copy of the left matrix,
// predicts every product column (exact sum, floor shift, 32-bit clamp)
// and compares each output beat field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_matrix4_column_multiply;

    import mcm_pkg::*;

    localparam int    N_RANDOM       = 1800;
    localparam int    N_CALM         = 300;   // last beats sent with no idling
    localparam int    RX_HOLD_CYCLES = 300;
    localparam int    QUIET_LIMIT    = 3000;
    localparam int    TAIL_CYCLES    = 24;
    localparam int    MAX_REPORTS    = 10;

    localparam logic [31:0] Q_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_NEG_MAX = 32'h8000_0000;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_LSB     = 32'h0000_0001;
    localparam logic [31:0] Q_M_LSB   = 32'hFFFF_FFFF;

    localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SUM_MIN = -66'sd2147483648;

    // One beat on the input channel
    typedef struct packed {
        logic             kind;
        logic [1:0]       col;
        logic [3:0][31:0] row;
    } col_beat_t;

    // One beat on the result channel
    typedef struct packed {
        logic [1:0]       col;
        logic [3:0][31:0] prod;
        logic             sat;
    } prod_beat_t;

    // Left-matrix mirror, product predictor and in-order comparison
    class product_checker;
        logic [31:0] left_q [16];
        prod_beat_t  pending_products [$];
        int          errors;

        function new();
            foreach (left_q[i]) left_q[i] = '0;
            errors = 0;
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch %s: expected %08h, got %08h", what, want, got);
        endfunction

        function prod_beat_t predict_column(col_beat_t b);
            prod_beat_t       res;
            logic signed [65:0] acc;
            logic signed [65:0] shifted;
            longint           term;
            res.col  = b.col;
            res.sat  = 1'b0;
            res.prod = '0;
            for (int r = 0; r < IN_ROWS; r++) begin
                acc = '0;
                for (int e = 0; e < IN_ROWS; e++) begin
                    term = longint'($signed(left_q[r + e * IN_ROWS]))
                         * longint'($signed(b.row[e]));
                    acc = acc + term;
                end
                shifted = acc >>> FRAC_W;
                // clamp to the signed 32-bit range
                if (shifted > SUM_MAX) begin
                    res.prod[r] = Q_POS_MAX;
                    res.sat     = 1'b1;
                end else if (shifted < SUM_MIN) begin
                    res.prod[r] = Q_NEG_MAX;
                    res.sat     = 1'b1;
                end else begin
                    res.prod[r] = shifted[31:0];
                end
            end
            return res;
        endfunction

        // Accepted input beat: a load updates the mirror, a multiply queues
        function void note_beat(col_beat_t b);
            if (b.kind == KIND_LOAD) begin
                for (int r = 0; r < IN_ROWS; r++)
                    left_q[r + int'(b.col) * IN_ROWS] = b.row[r];
            end else begin
                pending_products.push_back(predict_column(b));
            end
        endfunction

        function void check_product(prod_beat_t got);
            prod_beat_t want;
            if (pending_products.size() == 0) begin
                flag("unexpected product beat, column", '0, 32'(got.col));
                return;
            end
            want = pending_products.pop_front();
            if (got.col !== want.col)
                flag("out_col", 32'(want.col), 32'(got.col));
            for (int r = 0; r < IN_ROWS; r++)
                if (got.prod[r] !== want.prod[r])
                    flag($sformatf("prod_row%0d", r), want.prod[r], got.prod[r]);
            if (got.sat !== want.sat)
                flag("sat_flag", 32'(want.sat), 32'(got.sat));
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic [1:0]         s_col_index;
    logic signed [31:0] s_val_row0;
    logic signed [31:0] s_val_row1;
    logic signed [31:0] s_val_row2;
    logic signed [31:0] s_val_row3;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_out_col;
    logic signed [31:0] m_prod_row0;
    logic signed [31:0] m_prod_row1;
    logic signed [31:0] m_prod_row2;
    logic signed [31:0] m_prod_row3;
    logic               m_sat_flag;

    product_checker sb = new();

    int         send_idle_pct;
    int         recv_idle_pct;
    logic       hold_request;
    int         quiet_cycles;
    prod_beat_t seen_product;

    matrix4_column_multiply dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_col_index (s_col_index),
        .s_val_row0  (s_val_row0),
        .s_val_row1  (s_val_row1),
        .s_val_row2  (s_val_row2),
        .s_val_row3  (s_val_row3),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_col   (m_out_col),
        .m_prod_row0 (m_prod_row0),
        .m_prod_row1 (m_prod_row1),
        .m_prod_row2 (m_prod_row2),
        .m_prod_row3 (m_prod_row3),
        .m_sat_flag  (m_sat_flag)
    );

    // 12-unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Output monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_product.col     = m_out_col;
            seen_product.prod[0] = m_prod_row0;
            seen_product.prod[1] = m_prod_row1;
            seen_product.prod[2] = m_prod_row2;
            seen_product.prod[3] = m_prod_row3;
            seen_product.sat     = m_sat_flag;
            sb.check_product(seen_product);
        end
    end

    // Watchdog: no beat on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result-side ready: random stall bursts, plus one long hold on request
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready      = 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge aclk);
            end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
                m_ready = 1'b0;
                stall   = $urandom_range(1, 12);
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    function automatic col_beat_t make_beat(logic kind, logic [1:0] col, logic [31:0] r0,
                                            logic [31:0] r1, logic [31:0] r2,
                                            logic [31:0] r3);
        col_beat_t b;
        b.kind   = kind;
        b.col    = col;
        b.row[0] = r0;
        b.row[1] = r1;
        b.row[2] = r2;
        b.row[3] = r3;
        return b;
    endfunction

    // Q16.16 value; narrow mode keeps most values within +/-4.0
    function automatic logic [31:0] rand_q(bit narrow);
        int pick;
        int v;
        pick = narrow ? (($urandom_range(0, 9) < 8) ? 3 : $urandom_range(0, 9))
                      : $urandom_range(0, 9);
        case (pick)
            0, 1, 2: return $urandom();
            3, 4, 5: begin
                v = int'($urandom_range(0, 1 << 19)) - (1 << 18);
                return v;
            end
            6: begin
                case ($urandom_range(0, 5))
                    0: return Q_POS_MAX;
                    1: return Q_NEG_MAX;
                    2: return Q_ONE;
                    3: return Q_LSB;
                    4: return Q_M_LSB;
                    default: return '0;
                endcase
            end
            7: begin
                // near either end of the range
                v = int'($urandom_range(0, 4095));
                return $urandom_range(0, 1) ? (Q_POS_MAX - v) : (Q_NEG_MAX + v);
            end
            default: begin
                // fraction only
                v = int'($urandom_range(0, 65535));
                return $urandom_range(0, 1) ? v : -v;
            end
        endcase
    endfunction

    // Present one beat from a falling edge; returns at the falling edge after it is taken
    task automatic send_beat(input col_beat_t b);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            gap     = $urandom_range(1, 12);
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_kind      = b.kind;
        s_col_index = b.col;
        s_val_row0  = b.row[0];
        s_val_row1  = b.row[1];
        s_val_row2  = b.row[2];
        s_val_row3  = b.row[3];
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(b);
        @(negedge aclk);
    endtask

    task automatic send_random(logic kind, logic [1:0] col, bit narrow);
        send_beat(make_beat(kind, col, rand_q(narrow), rand_q(narrow),
                            rand_q(narrow), rand_q(narrow)));
    endtask

    // Stimulus
    initial begin
        int   sent;
        int   nload;
        int   nmul;
        int   first;
        int   step;
        int   mode_pick;
        bit   narrow;
        bit   hold_done;
        bit   pause_done;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = KIND_LOAD;
        s_col_index   = '0;
        s_val_row0    = '0;
        s_val_row1    = '0;
        s_val_row2    = '0;
        s_val_row3    = '0;
        hold_request  = 1'b0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: reset matrix, identity, clamp both ways, floor on negatives
        send_beat(make_beat(KIND_MUL, 2'd3, Q_POS_MAX, Q_NEG_MAX, Q_M_LSB, Q_LSB));
        send_beat(make_beat(KIND_LOAD, 2'd0, Q_ONE, '0, '0, '0));
        send_beat(make_beat(KIND_LOAD, 2'd1, '0, Q_ONE, '0, '0));
        send_beat(make_beat(KIND_LOAD, 2'd2, '0, '0, Q_ONE, '0));
        send_beat(make_beat(KIND_LOAD, 2'd3, '0, '0, '0, Q_ONE));
        send_beat(make_beat(KIND_MUL, 2'd1, Q_POS_MAX, Q_NEG_MAX, Q_M_LSB, Q_LSB));
        for (int c = 0; c < IN_ROWS; c++)
            send_beat(make_beat(KIND_LOAD, c[1:0], Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX,
                                Q_NEG_MAX));
        send_beat(make_beat(KIND_MUL, 2'd2, Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX));
        send_beat(make_beat(KIND_MUL, 2'd0, Q_POS_MAX, Q_POS_MAX, Q_POS_MAX, Q_POS_MAX));
        for (int c = 0; c < IN_ROWS; c++)
            send_beat(make_beat(KIND_LOAD, c[1:0], Q_M_LSB, Q_M_LSB, Q_M_LSB, Q_M_LSB));
        send_beat(make_beat(KIND_MUL, 2'd0, Q_LSB, Q_LSB, Q_LSB, Q_LSB));
        send_beat(make_beat(KIND_MUL, 2'd3, Q_M_LSB, Q_M_LSB, Q_M_LSB, Q_M_LSB));
        // columns 0 and 1 at 1.0: sums land one LSB past either end
        send_beat(make_beat(KIND_LOAD, 2'd0, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_beat(make_beat(KIND_LOAD, 2'd1, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_beat(make_beat(KIND_MUL, 2'd1, Q_POS_MAX, Q_LSB, '0, '0));
        send_beat(make_beat(KIND_MUL, 2'd2, Q_NEG_MAX, Q_M_LSB, '0, '0));
        send_beat(make_beat(KIND_MUL, 2'd0, Q_POS_MAX, '0, '0, '0));

        // Random: mostly load-then-multiply runs, some stray beats
        sent = 0;
        while (sent < N_RANDOM) begin
            if (sent >= N_RANDOM - N_CALM) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                mode_pick = $urandom_range(0, 2);
                send_idle_pct = (mode_pick == 0) ? 0 : (mode_pick == 1) ? 10 : 30;
                mode_pick = $urandom_range(0, 2);
                recv_idle_pct = (mode_pick == 0) ? 0 : (mode_pick == 1) ? 4 : 12;
            end
            // long receiver hold while beats keep coming
            if (!hold_done && sent >= 500) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            // sender pause until every product has come back
            if (!pause_done && sent >= 1100) begin
                s_valid = 1'b0;
                while (sb.pending_products.size() != 0) @(negedge aclk);
                pause_done = 1'b1;
            end
            narrow = $urandom_range(0, 2) != 0;
            if ($urandom_range(0, 9) < 8) begin
                nload = $urandom_range(1, 4);
                first = $urandom_range(0, 3);
                step  = $urandom_range(0, 1) ? 1 : 3;
                for (int k = 0; k < nload; k++) begin
                    send_random(KIND_LOAD, 2'(first + k * step), narrow);
                    sent++;
                end
                nmul = $urandom_range(2, 8);
                for (int k = 0; k < nmul; k++) begin
                    send_random(KIND_MUL, 2'($urandom_range(0, 3)), narrow);
                    sent++;
                end
            end else begin
                nmul = $urandom_range(1, 4);
                for (int k = 0; k < nmul; k++) begin
                    send_random(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), narrow);
                    sent++;
                end
            end
        end

        // Drain, then a short tail for stray beats
        s_valid = 1'b0;
        while (sb.pending_products.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_products.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/mcm_pkg.sv
rtl/mcm_ctrl.sv
rtl/mcm_datapath.sv
rtl/matrix4_column_multiply.sv
sim/tb_matrix4_column_multiply.sv
